FILE: rtl/core/lsps_pkg.sv
// Shared types, constants and arithmetic helpers for the line style pixel shade unit.
package lsps_pkg;

   // Fixed-point formats: values are unsigned Q0.16, distance is unsigned Q4.8.
   localparam int VALUE_BITS = 16;
   localparam int DIST_BITS  = 12;
   localparam int ONE_INT    = 1 << VALUE_BITS;
   localparam int STAGES     = 17;

   localparam logic [16:0] ONE_V     = 17'(ONE_INT);
   localparam logic [17:0] THREE_ONE = 18'(3 * ONE_INT);
   localparam logic [15:0] FULL_V    = 16'(ONE_INT - 1);
   localparam logic [16:0] HALF_V    = 17'(ONE_INT / 2);

   // Style register codes.
   localparam logic [1:0] STYLE_CLASSIC    = 2'd0;
   localparam logic [1:0] STYLE_SHADOWED   = 2'd1;
   localparam logic [1:0] STYLE_ADAPTIVE   = 2'd2;
   localparam logic [1:0] STYLE_ADAPTIVE_B = 2'd3;

   // Register index decoded from the word address.
   localparam logic STYLE_INDEX = 1'b0;

   // Smoothstep edges, scaled by 100 and by one.
   localparam logic [22:0] BASE_A = 23'(55 * ONE_INT);
   localparam logic [22:0] SPAN_A = 23'(15 * ONE_INT);
   localparam logic [22:0] HALF_A = 23'(15 / 2);
   localparam logic [22:0] BASE_B = 23'(84 * ONE_INT);
   localparam logic [22:0] SPAN_B = 23'(13 * ONE_INT);
   localparam logic [22:0] HALF_B = 23'(13 / 2);
   localparam logic [22:0] BASE_G = 23'(12 * ONE_INT);
   localparam logic [22:0] SPAN_G = 23'(23 * ONE_INT);
   localparam logic [22:0] HALF_G = 23'(23 / 2);

   // Reciprocals for exact division by small constants: floor(n/d) = (n*M) >> k.
   localparam logic [21:0] RECIP5   = 22'd3355444;   // k = 24
   localparam logic [20:0] RECIP15  = 21'd1118482;   // k = 24
   localparam logic [20:0] RECIP13  = 21'd1290556;   // k = 24
   localparam logic [20:0] RECIP23  = 21'd1458889;   // k = 25
   localparam logic [23:0] RECIP100 = 24'd10737419;  // k = 30

   // Percent scalings.
   localparam logic [22:0] PCT_SHADOW  = 23'd65;
   localparam logic [22:0] PCT_TONE_LO = 23'd58;
   localparam logic [22:0] PCT_TONE_HI = 23'd42;
   localparam logic [22:0] PCT_RIM     = 23'd35;
   localparam logic [22:0] PCT_ROUND   = 23'd50;

   // One pipeline slot; each stage fills in the fields it owns.
   typedef struct packed {
      logic [1:0]  style;
      logic [15:0] bg;
      logic [15:0] key;
      logic [16:0] cov_c;
      logic [18:0] plat_n;
      logic [16:0] cov_p;
      logic [16:0] rim_hi;
      logic [16:0] rim_diff;
      logic [5:0]  rim_frac;
      logic        rim_on;
      logic [16:0] rim;
      logic [16:0] t_sh;
      logic [16:0] sq_sh;
      logic [16:0] s_sh;
      logic [20:0] num_a;
      logic [20:0] num_b;
      logic [16:0] t_a;
      logic [16:0] t_b;
      logic [16:0] sq_a;
      logic [16:0] sq_b;
      logic [16:0] s_a;
      logic [16:0] s_b;
      logic [22:0] pn_a;
      logic [22:0] pn_b;
      logic [16:0] p_a;
      logic [16:0] p_b;
      logic [16:0] tone;
      logic [16:0] gap;
      logic [20:0] num_g;
      logic [16:0] t_g;
      logic [16:0] sq_g;
      logic [16:0] s_g;
      logic [16:0] y;
      logic [22:0] pn;
      logic [16:0] q;
      logic [15:0] blend_c;
      logic [16:0] blend_t;
      logic [16:0] blend_cov;
      logic        up;
      logic [16:0] prod;
      logic [15:0] shaded;
   } slot_type;

   // Rounded product of two Q0.16 values.
   function automatic logic [16:0] qmul(input logic [17:0] a, input logic [17:0] b);
      logic [35:0] p;
      p = 36'(a) * 36'(b) + 36'(ONE_INT / 2);
      return p[32:16];
   endfunction

   // Second smoothstep factor, 3 - 2t.
   function automatic logic [17:0] smooth_gain(input logic [16:0] t);
      return THREE_ONE - {t, 1'b0};
   endfunction

   // Clamped ramp numerator with the rounding half added, ready for the reciprocal.
   function automatic logic [20:0] ramp_num(input logic [22:0] x100, input logic [22:0] base,
                                            input logic [22:0] span, input logic [22:0] half);
      logic [22:0] num;
      num = (x100 <= base) ? 23'd0 : x100 - base;
      if (num > span) begin
         num = span;
      end
      return 21'(num + half);
   endfunction

   // Gaussian rim samples exp(-d*d/5.12), Q0.16, every quarter of distance.
   function automatic logic [16:0] rim_sample(input logic [5:0] idx);
      logic [16:0] r;
      unique case (idx)
         6'd0:    r = 17'd65536;
         6'd1:    r = 17'd64741;
         6'd2:    r = 17'd62413;
         6'd3:    r = 17'd58717;
         6'd4:    r = 17'd53908;
         6'd5:    r = 17'd48300;
         6'd6:    r = 17'd42231;
         6'd7:    r = 17'd36034;
         6'd8:    r = 17'd30005;
         6'd9:    r = 17'd24382;
         6'd10:   r = 17'd19335;
         6'd11:   r = 17'd14963;
         6'd12:   r = 17'd11300;
         6'd13:   r = 17'd8328;
         6'd14:   r = 17'd5989;
         6'd15:   r = 17'd4204;
         6'd16:   r = 17'd2879;
         6'd17:   r = 17'd1925;
         6'd18:   r = 17'd1255;
         6'd19:   r = 17'd799;
         6'd20:   r = 17'd496;
         6'd21:   r = 17'd301;
         6'd22:   r = 17'd178;
         6'd23:   r = 17'd103;
         6'd24:   r = 17'd58;
         6'd25:   r = 17'd32;
         6'd26:   r = 17'd17;
         6'd27:   r = 17'd9;
         6'd28:   r = 17'd5;
         6'd29:   r = 17'd2;
         6'd30:   r = 17'd1;
         6'd31:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/line_style_pixel_shade_unit.sv
// Top level of the line style pixel shade unit: style register and the shading pipeline.
//
//   channel   direction  handshake                  payload
//   req       in         req_valid / req_stall      req_background, req_key_luma, req_distance
//   rsp       out        rsp_valid / rsp_stall      rsp_shaded
//   csr       in/out     APB write at penable       csr_pwdata -> line_style (address 0)
//
// One word enters per clock while req_stall is low; an accepted word moves through the stage
// registers in order, and rsp_valid rises when it reaches the last one.
// The depth is set by the chain of rounded products and reciprocal divides of the
// adaptive style, with at most one multiply of that chain in each stage.
// Reset clears the valid bits and sets the style to classic; the data registers are not reset.
// A stalled result holds in the output stage while bubbles ahead of it still close up,
// so req_stall rises only when every stage holds a word and the output is stalled.
module line_style_pixel_shade_unit
   import lsps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_background,
   input  logic [15:0] req_key_luma,
   input  logic [11:0] req_distance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_shaded,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [1:0]        style_ff;
   logic              csr_write;
   slot_type          stage_ff [STAGES];
   slot_type          stage_in [STAGES];
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] advance;
   logic              in_take;
   logic              out_take;

   // Configuration port: single style register at word address zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == STYLE_INDEX);
   assign csr_prdata = (csr_paddr[2] == STYLE_INDEX) ? {30'd0, style_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff <= STYLE_CLASSIC;
      end else if (csr_write) begin
         style_ff <= csr_pwdata[1:0];
      end
   end

   // Stage flow control: a stage moves when it is empty or the stage after it moves.
   assign advance[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
   for (genvar g = 0; g < STAGES - 1; g++) begin : g_ready
      assign advance[g] = !valid_ff[g] || advance[g+1];
   end

   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};
   assign req_stall = !advance[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_shaded = stage_ff[STAGES-1].shaded;
   assign in_take   = req_valid && !req_stall;
   assign out_take  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_in & advance) | (valid_ff & ~advance);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (advance[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // Stage 0: coverages from distance, rim table lookup, ramp numerators from the key.
   always_comb begin : s0
      logic [13:0] triple_d;
      logic [9:0]  cc;
      logic [7:0]  w;
      logic [22:0] key_x100;
      logic [5:0]  rim_idx;
      logic [16:0] rim_lo;
      triple_d = 14'(req_distance) * 14'd3;
      cc = (triple_d >= 14'd640) ? 10'd0 : 10'(14'd640 - triple_d);
      if (cc > 10'd256) begin
         cc = 10'd256;
      end
      if (req_distance >= 12'd320) begin
         w = 8'd0;
      end else if (req_distance <= 12'd160) begin
         w = 8'd160;
      end else begin
         w = 8'(12'd320 - req_distance);
      end
      key_x100 = 23'(req_key_luma) * 23'd100;
      rim_idx  = {1'b0, req_distance[10:6]};
      rim_lo   = rim_sample(rim_idx + 6'd1);

      stage_in[0]          = '0;
      stage_in[0].style    = style_ff;
      stage_in[0].bg       = req_background;
      stage_in[0].key      = req_key_luma;
      stage_in[0].cov_c    = {cc[8:0], 8'd0};
      stage_in[0].plat_n   = {w, 11'd0} + 19'd2;
      stage_in[0].rim_hi   = rim_sample(rim_idx);
      stage_in[0].rim_diff = stage_in[0].rim_hi - rim_lo;
      stage_in[0].rim_frac = req_distance[5:0];
      stage_in[0].rim_on   = !req_distance[11];
      if (req_key_luma <= 16'd16384) begin
         stage_in[0].t_sh = 17'd0;
      end else if (req_key_luma >= 16'd49152) begin
         stage_in[0].t_sh = ONE_V;
      end else begin
         stage_in[0].t_sh = {req_key_luma, 1'b0} - HALF_V;
      end
      stage_in[0].num_a = ramp_num(key_x100, BASE_A, SPAN_A, HALF_A);
      stage_in[0].num_b = ramp_num(key_x100, BASE_B, SPAN_B, HALF_B);
   end

   // Stage 1: plateau coverage, rim interpolation, ramp positions by reciprocal.
   always_comb begin : s1
      logic [40:0] cov_prod;
      logic [22:0] rim_step;
      logic [41:0] ta_prod;
      logic [41:0] tb_prod;
      cov_prod = 41'(stage_ff[0].plat_n) * 41'(RECIP5);
      rim_step = 23'(stage_ff[0].rim_diff) * 23'(stage_ff[0].rim_frac);
      ta_prod  = 42'(stage_ff[0].num_a) * 42'(RECIP15);
      tb_prod  = 42'(stage_ff[0].num_b) * 42'(RECIP13);
      stage_in[1]       = stage_ff[0];
      stage_in[1].cov_p = cov_prod[40:24];
      stage_in[1].rim   = stage_ff[0].rim_on ? stage_ff[0].rim_hi - rim_step[22:6] : 17'd0;
      stage_in[1].t_a   = ta_prod[40:24];
      stage_in[1].t_b   = tb_prod[40:24];
   end

   // Stage 2: squares of the three ramp positions.
   always_comb begin : s2
      stage_in[2]       = stage_ff[1];
      stage_in[2].sq_sh = qmul({1'b0, stage_ff[1].t_sh}, {1'b0, stage_ff[1].t_sh});
      stage_in[2].sq_a  = qmul({1'b0, stage_ff[1].t_a}, {1'b0, stage_ff[1].t_a});
      stage_in[2].sq_b  = qmul({1'b0, stage_ff[1].t_b}, {1'b0, stage_ff[1].t_b});
   end

   // Stage 3: finish the three smoothsteps.
   always_comb begin : s3
      stage_in[3]      = stage_ff[2];
      stage_in[3].s_sh = qmul({1'b0, stage_ff[2].sq_sh}, smooth_gain(stage_ff[2].t_sh));
      stage_in[3].s_a  = qmul({1'b0, stage_ff[2].sq_a}, smooth_gain(stage_ff[2].t_a));
      stage_in[3].s_b  = qmul({1'b0, stage_ff[2].sq_b}, smooth_gain(stage_ff[2].t_b));
   end

   // Stage 4: percent scaling numerators of the tone steps.
   always_comb begin : s4
      stage_in[4]      = stage_ff[3];
      stage_in[4].pn_a = 23'(stage_ff[3].s_a) * PCT_TONE_LO + PCT_ROUND;
      stage_in[4].pn_b = 23'(stage_ff[3].s_b) * PCT_TONE_HI + PCT_ROUND;
   end

   // Stage 5: divide the percent numerators by 100.
   always_comb begin : s5
      logic [46:0] pa_prod;
      logic [46:0] pb_prod;
      pa_prod = 47'(stage_ff[4].pn_a) * 47'(RECIP100);
      pb_prod = 47'(stage_ff[4].pn_b) * 47'(RECIP100);
      stage_in[5]     = stage_ff[4];
      stage_in[5].p_a = pa_prod[46:30];
      stage_in[5].p_b = pb_prod[46:30];
   end

   // Stage 6: tone, clamped at zero, and its distance from the key.
   always_comb begin : s6
      logic [17:0] drop;
      logic [16:0] tone;
      drop = 18'(stage_ff[5].p_a) + 18'(stage_ff[5].p_b);
      tone = (drop >= 18'(ONE_V)) ? 17'd0 : 17'(18'(ONE_V) - drop);
      stage_in[6]      = stage_ff[5];
      stage_in[6].tone = tone;
      stage_in[6].gap  = (tone >= 17'(stage_ff[5].key)) ? tone - 17'(stage_ff[5].key)
                                                        : 17'(stage_ff[5].key) - tone;
   end

   // Stage 7: ramp numerator of the gap smoothstep.
   always_comb begin : s7
      stage_in[7]       = stage_ff[6];
      stage_in[7].num_g = ramp_num(23'(stage_ff[6].gap) * 23'd100, BASE_G, SPAN_G, HALF_G);
   end

   // Stage 8: gap ramp position by reciprocal.
   always_comb begin : s8
      logic [41:0] tg_prod;
      tg_prod = 42'(stage_ff[7].num_g) * 42'(RECIP23);
      stage_in[8]     = stage_ff[7];
      stage_in[8].t_g = tg_prod[41:25];
   end

   // Stage 9: square of the gap position.
   always_comb begin : s9
      stage_in[9]      = stage_ff[8];
      stage_in[9].sq_g = qmul({1'b0, stage_ff[8].t_g}, {1'b0, stage_ff[8].t_g});
   end

   // Stage 10: finish the gap smoothstep.
   always_comb begin : s10
      stage_in[10]     = stage_ff[9];
      stage_in[10].s_g = qmul({1'b0, stage_ff[9].sq_g}, smooth_gain(stage_ff[9].t_g));
   end

   // Stage 11: rim weighted by the key ramp or by the tone contrast.
   always_comb begin : s11
      logic [16:0] weight;
      weight = (stage_ff[10].style == STYLE_SHADOWED) ? stage_ff[10].s_sh
                                                      : ONE_V - stage_ff[10].s_g;
      stage_in[11]   = stage_ff[10];
      stage_in[11].y = qmul({1'b0, stage_ff[10].rim}, {1'b0, weight});
   end

   // Stage 12: percent numerator of the shadow depth.
   always_comb begin : s12
      stage_in[12] = stage_ff[11];
      if (stage_ff[11].style == STYLE_SHADOWED) begin
         stage_in[12].pn = 23'(stage_ff[11].y) * PCT_SHADOW + PCT_ROUND;
      end else begin
         stage_in[12].pn = 23'(stage_ff[11].y) * PCT_RIM + PCT_ROUND;
      end
   end

   // Stage 13: shadow depth divided by 100.
   always_comb begin : s13
      logic [46:0] q_prod;
      q_prod = 47'(stage_ff[12].pn) * 47'(RECIP100);
      stage_in[13]   = stage_ff[12];
      stage_in[13].q = q_prod[46:30];
   end

   // Stage 14: darkened background and the blend target chosen by style.
   always_comb begin : s14
      logic [16:0] dark;
      dark = qmul(18'(stage_ff[13].bg), {1'b0, ONE_V - stage_ff[13].q});
      stage_in[14] = stage_ff[13];
      unique case (stage_ff[13].style)
         STYLE_CLASSIC: begin
            stage_in[14].blend_c   = stage_ff[13].bg;
            stage_in[14].blend_t   = stage_ff[13].key[15] ? 17'd0 : ONE_V;
            stage_in[14].blend_cov = stage_ff[13].cov_c;
         end
         STYLE_SHADOWED: begin
            stage_in[14].blend_c   = dark[15:0];
            stage_in[14].blend_t   = ONE_V;
            stage_in[14].blend_cov = stage_ff[13].cov_p;
         end
         STYLE_ADAPTIVE, STYLE_ADAPTIVE_B: begin
            stage_in[14].blend_c   = dark[15:0];
            stage_in[14].blend_t   = stage_ff[13].tone;
            stage_in[14].blend_cov = stage_ff[13].cov_p;
         end
      endcase
   end

   // Stage 15: coverage-weighted step toward the target.
   always_comb begin : s15
      logic        up;
      logic [16:0] mag;
      up  = stage_ff[14].blend_t >= 17'(stage_ff[14].blend_c);
      mag = up ? stage_ff[14].blend_t - 17'(stage_ff[14].blend_c)
               : 17'(stage_ff[14].blend_c) - stage_ff[14].blend_t;
      stage_in[15]      = stage_ff[14];
      stage_in[15].up   = up;
      stage_in[15].prod = qmul({1'b0, mag}, {1'b0, stage_ff[14].blend_cov});
   end

   // Stage 16: apply the step and saturate at full scale.
   always_comb begin : s16
      logic [17:0] res;
      res = stage_ff[15].up ? 18'(stage_ff[15].blend_c) + 18'(stage_ff[15].prod)
                            : 18'(stage_ff[15].blend_c) - 18'(stage_ff[15].prod);
      stage_in[16]        = stage_ff[15];
      stage_in[16].shaded = (res > 18'(FULL_V)) ? FULL_V : res[15:0];
   end

   // The input stalls only when every stage holds a word.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled while the pipeline has a free stage");

   // With the output draining, the input never stalls.
   a_stall_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while the output is taken");

   // Occupancy follows accepted and delivered words exactly.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(valid_ff) + int'($past(out_take)) ==
                         $past($countones(valid_ff)) + int'($past(in_take))))
      else $error("word lost or duplicated in the pipeline");

endmodule

FILE: tb/line_style_pixel_shade_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the line style pixel shade unit: predicts every shaded word and compares it.
module line_style_pixel_shade_checker
   import lsps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_background,
   input  logic [15:0] req_key_luma,
   input  logic [11:0] req_distance,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_shaded,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          words_pending
);

   localparam longint UNIT = 65536;

   // One accepted pixel together with the shade it must come back with.
   typedef struct packed {
      logic [1:0]  style;
      logic [15:0] bg;
      logic [15:0] key;
      logic [11:0] pix_dist;
      logic [15:0] shaded;
   } shade_job_type;

   shade_job_type shade_due[$];
   shade_job_type job;
   logic [1:0]    style_now;

   // Product of two Q0.16 values, rounded half up.
   function automatic longint mul_round(input longint a, input longint b);
      return (a * b + UNIT / 2) >>> 16;
   endfunction

   // Scaling by a whole percentage, rounded half up.
   function automatic longint pct_of(input longint v, input longint p);
      return (v * p + 50) / 100;
   endfunction

   // Smoothstep between lo/100 and hi/100 with the rounded ramp and two rounded products.
   function automatic longint smooth_pct(input longint x, input longint lo, input longint hi);
      longint span;
      longint num;
      longint t;
      span = hi - lo;
      num  = x * 100 - lo * UNIT;
      if (num < 0) begin
         num = 0;
      end
      if (num > span * UNIT) begin
         num = span * UNIT;
      end
      t = (num + span / 2) / span;
      return mul_round(mul_round(t, t), 3 * UNIT - 2 * t);
   endfunction

   // Gaussian rim exp(-d*d/5.12) in Q0.16, sampled every quarter of distance.
   function automatic longint rim_at(input longint idx);
      case (idx)
         0:       return 65536;
         1:       return 64741;
         2:       return 62413;
         3:       return 58717;
         4:       return 53908;
         5:       return 48300;
         6:       return 42231;
         7:       return 36034;
         8:       return 30005;
         9:       return 24382;
         10:      return 19335;
         11:      return 14963;
         12:      return 11300;
         13:      return 8328;
         14:      return 5989;
         15:      return 4204;
         16:      return 2879;
         17:      return 1925;
         18:      return 1255;
         19:      return 799;
         20:      return 496;
         21:      return 301;
         22:      return 178;
         23:      return 103;
         24:      return 58;
         25:      return 32;
         26:      return 17;
         27:      return 9;
         28:      return 5;
         29:      return 2;
         30:      return 1;
         31:      return 1;
         default: return 0;
      endcase
   endfunction

   // Composited channel value for one pixel under the given style.
   function automatic logic [15:0] shade_pixel(input logic [1:0] style, input logic [15:0] bg_in,
                                               input logic [15:0] key_in,
                                               input logic [11:0] dist_in);
      longint bg;
      longint key;
      longint d;
      longint cov;
      longint covp;
      longint rim;
      longint hi_s;
      longint lo_s;
      longint c;
      longint tone;
      longint gap;
      longint res;
      bg  = bg_in;
      key = key_in;
      d   = dist_in;
      if (style == STYLE_CLASSIC) begin
         // Coverage clamp(2.5 - 3d) in Q4.8, then a hard key at one half.
         cov = 640 - 3 * d;
         if (cov < 0) begin
            cov = 0;
         end
         if (cov > 256) begin
            cov = 256;
         end
         cov = (cov * UNIT + 128) >>> 8;
         if (key < UNIT / 2) begin
            res = bg + mul_round(UNIT - bg, cov);
         end else begin
            res = bg - mul_round(bg, cov);
         end
      end else begin
         // Plateau coverage clamp(2 - 1.6d), formed as (10 - 8d) / 5.
         covp = 2560 - 8 * d;
         if (covp < 0) begin
            covp = 0;
         end
         if (covp > 1280) begin
            covp = 1280;
         end
         covp = (covp * UNIT + 640) / 1280;

         // Rim from the table, linear between samples with the step truncated.
         if ((d >>> 6) >= 32) begin
            rim = 0;
         end else begin
            hi_s = rim_at(d >>> 6);
            lo_s = rim_at((d >>> 6) + 1);
            rim  = hi_s - (((hi_s - lo_s) * (d & 63)) >>> 6);
            rim  = (rim * UNIT + 32768) >>> 16;
         end

         if (style == STYLE_SHADOWED) begin
            c   = mul_round(bg, UNIT - pct_of(mul_round(rim, smooth_pct(key, 25, 75)), 65));
            res = c + mul_round(UNIT - c, covp);
         end else begin
            // Adaptive tone ramp; rounding may push the tone below zero.
            tone = UNIT - pct_of(smooth_pct(key, 55, 70), 58)
                   - pct_of(smooth_pct(key, 84, 97), 42);
            if (tone < 0) begin
               tone = 0;
            end
            gap = (tone >= key) ? tone - key : key - tone;
            c   = mul_round(bg, UNIT - pct_of(mul_round(rim, UNIT - smooth_pct(gap, 12, 35)), 35));
            if (tone >= c) begin
               res = c + mul_round(tone - c, covp);
            end else begin
               res = c - mul_round(c - tone, covp);
            end
         end
      end
      // A result that reaches one saturates to full scale.
      if (res > UNIT - 1) begin
         res = UNIT - 1;
      end
      return res[15:0];
   endfunction

   // Track the style register, queue a prediction per accepted pixel, check each shaded word.
   always @(posedge clock) begin
      if (reset) begin
         style_now      <= STYLE_CLASSIC;
         mismatch_count <= 0;
         words_pending  <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == {STYLE_INDEX, 2'b00}) begin
            style_now <= csr_pwdata[1:0];
         end

         if (req_valid && !req_stall) begin
            job.style    = style_now;
            job.bg       = req_background;
            job.key      = req_key_luma;
            job.pix_dist = req_distance;
            job.shaded   = shade_pixel(style_now, req_background, req_key_luma, req_distance);
            shade_due.push_back(job);
         end

         if (rsp_valid && !rsp_stall) begin
            if (shade_due.size() == 0) begin
               $display("%0t: shaded word %h arrived with nothing pending", $time, rsp_shaded);
               mismatch_count <= mismatch_count + 1;
            end else begin
               job = shade_due.pop_front();
               if (rsp_shaded !== job.shaded) begin
                  $display({"%0t: shaded mismatch (style %0d bg %h key %h distance %h): ",
                            "expected %h, actual %h"},
                           $time, job.style, job.bg, job.key, job.pix_dist, job.shaded,
                           rsp_shaded);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end

         words_pending <= shade_due.size();
      end
   end

endmodule

FILE: tb/line_style_pixel_shade_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the line style pixel shade unit: clock, reset, stimulus and verdict.
module line_style_pixel_shade_unit_tb
   import lsps_pkg::*;
();

   localparam int     PHASES          = 8;
   localparam int     WORDS_PER_PHASE = 244;
   localparam int     HOLD_CYCLES     = 80;
   localparam longint LIMIT_NS        = 2_000_000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [15:0] req_background = '0;
   logic [15:0] req_key_luma   = '0;
   logic [11:0] req_distance   = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [15:0] rsp_shaded;
   logic        csr_psel       = 1'b0;
   logic        csr_penable    = 1'b0;
   logic        csr_pwrite     = 1'b0;
   logic [2:0]  csr_paddr      = '0;
   logic [31:0] csr_pwdata     = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int words_pending;
   int words_sent     = 0;
   int hold_left      = 0;
   bit hold_start     = 1'b0;
   bit hold_done      = 1'b0;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;

   always #5 clock = ~clock;

   line_style_pixel_shade_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_background (req_background),
      .req_key_luma   (req_key_luma),
      .req_distance   (req_distance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_shaded     (rsp_shaded),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   line_style_pixel_shade_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_background (req_background),
      .req_key_luma   (req_key_luma),
      .req_distance   (req_distance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_shaded     (rsp_shaded),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // Offer one pixel, possibly after some idle cycles, and wait until it is taken.
   task automatic send_word(input logic [15:0] bg, input logic [15:0] key,
                            input logic [11:0] pix_dist);
      while (sender_idles && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_background <= bg;
      req_key_luma   <= key;
      req_distance   <= pix_dist;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the style register through a setup and an access cycle; upper data bits are junk.
   task automatic write_style(input logic [1:0] style);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {STYLE_INDEX, 2'b00};
      csr_pwdata  <= {30'($urandom()), style};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Field extremes and the coverage and rim boundaries.
   task automatic send_edge_words();
      // Full white core over a full background: the sum reaches one and saturates.
      send_word(16'hffff, 16'h0000, 12'h000);
      // Dark background, bright key, distance saturated far from the stroke.
      send_word(16'h0000, 16'hffff, 12'hfff);
      // Classic coverage one step above zero, key just under one half.
      send_word(16'h8000, 16'h7fff, 12'h0d5);
      // Classic coverage clamped to zero, key exactly one half.
      send_word(16'h7fff, 16'h8000, 12'h0d6);
      // First distance past the end of the rim table.
      send_word(16'h1234, 16'hc000, 12'h800);
      // Last interpolated rim step with a full key, where the tone bottoms out.
      send_word(16'hffff, 16'hffff, 12'h7ff);
   endtask

   // Random pixel, weighted toward the stroke and toward the tone ramps of the key.
   task automatic send_random_word();
      logic [15:0] bg;
      logic [15:0] key;
      logic [11:0] pix_dist;
      bg = 16'($urandom());
      case ($urandom_range(9))
         0, 1, 2: key = 16'($urandom_range(16'h8000, 16'hffff));
         3:       key = ($urandom_range(1) != 0) ? 16'hffff : 16'h0000;
         default: key = 16'($urandom());
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: pix_dist = 12'($urandom_range(12'h2ff));
         4, 5, 6, 7: pix_dist = 12'($urandom());
         default: begin
            case ($urandom_range(5))
               0:       pix_dist = 12'h000;
               1:       pix_dist = 12'h080;
               2:       pix_dist = 12'h0d5;
               3:       pix_dist = 12'h7ff;
               4:       pix_dist = 12'h800;
               default: pix_dist = 12'hfff;
            endcase
         end
      endcase
      send_word(bg, key, pix_dist);
   endtask

   // Output side: a counted hold-off when asked, random stalls otherwise.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_start && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(99) < 15);
         end
      end
   end

   // Run limit.
   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d words still pending.", words_pending);
      $display("CHECKS FAILED");
      $finish;
   end

   // Main sequence: reset, directed words per style, then random phases.
   initial begin
      logic [1:0] style;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int s = 0; s < 4; s++) begin
         write_style(2'(s));
         send_edge_words();
         drain();
      end

      for (int p = 0; p < PHASES; p++) begin
         style = (p < 4) ? 2'(p) : 2'($urandom_range(3));
         sender_idles   = (p != 2);
         receiver_idles = (p != 2);
         write_style(style);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            // Hold the output long enough for the pipeline to fill and stall the input.
            if (p == 1 && i == 60) begin
               hold_start = 1'b1;
            end
            send_random_word();
         end
         drain();
      end

      repeat (24) @(posedge clock);
      $display("Sent %0d words through all four style codes with random gaps on both sides,",
               words_sent);
      $display("a %0d-cycle output hold-off and a back-to-back stretch.", HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
